// ===== hdl/join_leave_spam_detector_assert.svh =====
// Assertion macros for the join/leave spam detector.
// Used by the top level; no other dependencies.
`ifndef JOIN_LEAVE_SPAM_DETECTOR_ASSERT_SVH
`define JOIN_LEAVE_SPAM_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define JLSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("jlsd: assertion failed");
`define JLSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jlsd: assertion failed");
`else
`define JLSD_ASSERT(lbl, clk, rst_n, prop)
`define JLSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/jlsd_pkg.sv =====
// Shared types and constants of the join/leave spam detector.
// No dependencies.
package jlsd_pkg;

    localparam int IDX_W   = 8;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int CD_W    = 8;
    localparam int THR_W   = 8;
    localparam int WIN_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPAM_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REJOIN_WINDOW  = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [CD_W-1:0]    cdown;
        logic [TIME_W-1:0]  t_join;
        logic [TIME_W-1:0]  t_leave;
    } t_entry;

    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } t_calc_ctl;

    typedef struct packed {
        logic               warn;
        logic               warn_for_join;
        logic [COUNT_W-1:0] count;
        t_entry             entry;
    } t_calc_res;

endpackage

// ===== hdl/jlsd_in_if.sv =====
// Input event channel of the join/leave spam detector.
// Depends on jlsd_pkg.
interface jlsd_in_if import jlsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  client_index;
    logic [TIME_W-1:0] now_seconds;
    logic              is_join;

    modport source(output valid, client_index, now_seconds, is_join, input ready);
    modport sink(input valid, client_index, now_seconds, is_join, output ready);
endinterface

// ===== hdl/jlsd_out_if.sv =====
// Result channel of the join/leave spam detector.
// Depends on jlsd_pkg.
interface jlsd_out_if import jlsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               warn;
    logic               warn_for_join;
    logic [COUNT_W-1:0] activity_count;

    modport source(output valid, warn, warn_for_join, activity_count, input ready);
    modport sink(input valid, warn, warn_for_join, activity_count, output ready);
endinterface

// ===== hdl/jlsd_mem.sv =====
// Per-client state memory: one write port, one read port, registered read data.
// Depends on jlsd_pkg.
module jlsd_mem import jlsd_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/jlsd_calc.sv =====
// Two-stage update datapath: elapsed times, decay by reciprocal multiply, countdown.
// Depends on jlsd_pkg.
module jlsd_calc import jlsd_pkg::*; #(
    parameter int WARN_COUNTDOWN = 5,
    parameter int EXPIRE_SECONDS = 120
) (
    input  logic              i_clk,
    input  t_calc_ctl         i_ctl,
    input  t_entry            i_entry,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_join,
    input  logic [THR_W-1:0]  i_thresh,
    input  logic [WIN_W-1:0]  i_window,
    output t_calc_res         o_res
);
    localparam int  EXP_W  = $clog2(EXPIRE_SECONDS + 1);
    localparam int  LIM_W  = COUNT_W + 1 + EXP_W;
    localparam int  DIV_L  = $clog2(EXPIRE_SECONDS);
    localparam int  DIV_N  = COUNT_W + DIV_L;
    localparam int  DIV_MW = DIV_N + 1;
    localparam int  PROD_W = DIV_N + DIV_MW;
    localparam int  DIV_SH = DIV_N + DIV_L;
    localparam longint DIV_M_L =
        ((64'd1 << DIV_SH) + longint'(EXPIRE_SECONDS) - 1) / longint'(EXPIRE_SECONDS);
    localparam logic [DIV_MW-1:0] DIV_M  = DIV_M_L[DIV_MW-1:0];
    localparam logic [EXP_W-1:0]  EXP_C  = EXP_W'(EXPIRE_SECONDS);
    localparam logic [CD_W-1:0]   CD_RELOAD = CD_W'(WARN_COUNTDOWN);

    t_entry             r_entry;
    logic [TIME_W-1:0]  r_since_leave;
    logic               r_join_hit;
    logic               r_warn_path;
    logic               r_expired;
    logic [LIM_W-1:0]   r_limit;
    logic               r_all_gone;
    logic [PROD_W-1:0]  r_prod;

    logic [TIME_W-1:0]  w_since_leave;
    logic [TIME_W-1:0]  w_since_join;
    logic [COUNT_W-1:0] w_dec;
    logic [COUNT_W-1:0] w_count_dec;
    logic [COUNT_W-1:0] w_count_new;
    logic [CD_W-1:0]    w_cd_dec;
    logic               w_fire;
    t_entry             w_entry;

    assign w_since_leave = i_now - i_entry.t_leave;
    assign w_since_join  = i_now - i_entry.t_join;

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_en) begin
            r_entry       <= i_entry;
            r_since_leave <= w_since_leave;
            r_join_hit    <= w_since_join < TIME_W'(i_window);
            r_warn_path   <= (i_thresh != '0) && (i_entry.count >= i_thresh);
            r_expired     <= w_since_leave > TIME_W'(EXPIRE_SECONDS);
            r_limit       <= LIM_W'({1'b0, i_entry.count} + 9'd1) * LIM_W'(EXP_C);
        end
        if (i_ctl.s2_en) begin
            r_all_gone <= r_since_leave >= TIME_W'(r_limit);
            r_prod     <= PROD_W'(r_since_leave[DIV_N-1:0]) * PROD_W'(DIV_M);
        end
    end

    always_comb begin
        w_dec       = r_prod[DIV_SH +: COUNT_W];
        w_count_dec = r_all_gone ? '0 : r_entry.count - w_dec;
        if (r_expired) begin
            w_count_new = w_count_dec;
        end else if (r_join_hit && r_entry.count != COUNT_MAX) begin
            w_count_new = r_entry.count + 1'b1;
        end else begin
            w_count_new = r_entry.count;
        end
        w_cd_dec = (r_entry.cdown != '0) ? r_entry.cdown - 1'b1 : '0;
        w_fire   = w_cd_dec == '0;

        w_entry = r_entry;
        if (r_warn_path) begin
            w_entry.cdown = w_fire ? CD_RELOAD : w_cd_dec;
        end else begin
            w_entry.count = w_count_new;
            if (i_join) begin
                w_entry.t_join = i_now;
            end else begin
                w_entry.t_leave = i_now;
            end
        end

        o_res.warn          = r_warn_path && w_fire;
        o_res.warn_for_join = r_warn_path && w_fire && i_join;
        o_res.count         = w_entry.count;
        o_res.entry         = w_entry;
    end
endmodule

// ===== hdl/join_leave_spam_detector.sv =====
// Top level of the join/leave spam detector: sequencer, configuration, result register.
// Depends on jlsd_pkg, jlsd_in_if, jlsd_out_if, jlsd_mem, jlsd_calc and the assert header.
//
// One event at a time runs through a read-modify-write of its client entry in a single
// state memory: an event for a valid client passes through memory read, two datapath
// stages and write-back; an event whose client_index is at or beyond NUM_CLIENTS skips
// the datapath and leaves the memory untouched. The next event is taken while a result
// still waits in the output register. After reset the block clears the memory one entry
// per cycle until all NUM_CLIENTS entries are cleared and accepts no event until done;
// configuration writes are taken at any time.
`include "join_leave_spam_detector_assert.svh"

module join_leave_spam_detector import jlsd_pkg::*; #(
    parameter int NUM_CLIENTS    = 256,
    parameter int WARN_COUNTDOWN = 5,
    parameter int EXPIRE_SECONDS = 120
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jlsd_in_if.sink               i_in,
    jlsd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CLIENTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC1,
        S_CALC2,
        S_WRITE
    } t_state;

    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_addr;
    logic [TIME_W-1:0]  r_now;
    logic               r_join;
    logic               r_oor;
    logic [THR_W-1:0]   r_thresh;
    logic [WIN_W-1:0]   r_window;
    logic               r_out_valid;
    logic               r_out_warn;
    logic               r_out_wfj;
    logic [COUNT_W-1:0] r_out_count;

    logic               w_accept;
    logic               w_in_range;
    logic               w_out_free;
    logic               w_finish;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    t_entry             w_mem_wdata;
    t_entry             w_rdata;
    t_calc_ctl          w_ctl;
    t_calc_res          w_res;

    assign i_in.ready = r_state == S_IDLE;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = 32'(i_in.client_index) < 32'(NUM_CLIENTS);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_finish   = r_state == S_WRITE && w_out_free;

    assign w_mem_we    = (r_state == S_CLEAR) || (w_finish && !r_oor);
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_mem_wdata = (r_state == S_CLEAR) ? t_entry'('0) : w_res.entry;

    assign w_ctl.s1_en = r_state == S_CALC1;
    assign w_ctl.s2_en = r_state == S_CALC2;

    jlsd_mem #(
        .DEPTH(NUM_CLIENTS),
        .AW   (AW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr(w_mem_waddr),
        .i_wdata(w_mem_wdata),
        .i_raddr(AW'(i_in.client_index)),
        .o_rdata(w_rdata)
    );

    jlsd_calc #(
        .WARN_COUNTDOWN(WARN_COUNTDOWN),
        .EXPIRE_SECONDS(EXPIRE_SECONDS)
    ) u_calc (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_entry (w_rdata),
        .i_now   (r_now),
        .i_join  (r_join),
        .i_thresh(r_thresh),
        .i_window(r_window),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_thresh    <= '0;
            r_window    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPAM_THRESHOLD: r_thresh <= i_cfg_data[THR_W-1:0];
                    CFG_REJOIN_WINDOW:  r_window <= i_cfg_data[WIN_W-1:0];
                    default: ;
                endcase
            end

            if (o_out.ready && !w_finish) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_addr  <= AW'(i_in.client_index);
                        r_now   <= i_in.now_seconds;
                        r_join  <= i_in.is_join;
                        r_oor   <= !w_in_range;
                        r_state <= w_in_range ? S_CALC1 : S_WRITE;
                    end
                end
                S_CALC1: r_state <= S_CALC2;
                S_CALC2: r_state <= S_WRITE;
                S_WRITE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_warn  <= !r_oor && w_res.warn;
                        r_out_wfj   <= !r_oor && w_res.warn_for_join;
                        r_out_count <= r_oor ? '0 : w_res.count;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.warn           = r_out_warn;
    assign o_out.warn_for_join  = r_out_wfj;
    assign o_out.activity_count = r_out_count;

    `JLSD_ASSERT_IMP(a_one_event_at_a_time, i_clk, i_rst_n, w_accept, !i_in.ready)
    `JLSD_ASSERT(a_mem_write_owner, i_clk, i_rst_n, !w_mem_we || r_state == S_CLEAR || r_state == S_WRITE)
    `JLSD_ASSERT_IMP(a_result_on_finish, i_clk, i_rst_n, w_finish, r_out_valid && r_state == S_IDLE)
endmodule

// ===== sim/jlsd_event_checker.sv =====
// Checker for the join/leave spam detector: watches the event, result and register ports,
// predicts each verdict from its own copy of the client table and compares field by field.
// Depends on jlsd_pkg, jlsd_in_if and jlsd_out_if.
`timescale 1ns / 100ps

module jlsd_event_checker import jlsd_pkg::*; #(
    parameter int NUM_CLIENTS    = 256,
    parameter int WARN_COUNTDOWN = 5,
    parameter int EXPIRE_SECONDS = 120
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jlsd_in_if                    i_ev,
    jlsd_out_if                   i_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic               warn;
        logic               warn_for_join;
        logic [COUNT_W-1:0] count;
    } verdict_t;

    logic [THR_W-1:0]   threshold;
    logic [WIN_W-1:0]   window;
    logic [COUNT_W-1:0] counts   [NUM_CLIENTS];
    logic [CD_W-1:0]    cdowns   [NUM_CLIENTS];
    logic [TIME_W-1:0]  join_at  [NUM_CLIENTS];
    logic [TIME_W-1:0]  leave_at [NUM_CLIENTS];
    verdict_t           expected_verdicts [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report(string what, int unsigned want, int unsigned got);
        o_fail_count++;
        if (o_fail_count <= 100)
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    function automatic verdict_t judge_event(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now,
                                             logic joining);
        verdict_t           v;
        logic [COUNT_W-1:0] cnt;
        logic [CD_W-1:0]    cd;
        logic [TIME_W-1:0]  since_leave;
        logic [TIME_W-1:0]  since_join;
        logic [TIME_W-1:0]  decay;
        v = '0;
        if (int'(idx) >= NUM_CLIENTS)
            return v;
        cnt = counts[idx];
        if (threshold != '0 && cnt >= threshold) begin
            cd = cdowns[idx];
            if (cd != '0)
                cd--;
            if (cd == '0) begin
                cd              = CD_W'(WARN_COUNTDOWN);
                v.warn          = 1'b1;
                v.warn_for_join = joining;
            end
            cdowns[idx] = cd;
        end else begin
            since_leave = now - leave_at[idx];
            if (since_leave > TIME_W'(EXPIRE_SECONDS)) begin
                decay = since_leave / TIME_W'(EXPIRE_SECONDS);
                cnt   = (decay > cnt) ? '0 : cnt - COUNT_W'(decay);
            end else begin
                since_join = now - join_at[idx];
                if (since_join < window && cnt != '1)
                    cnt++;
            end
            counts[idx] = cnt;
            if (joining)
                join_at[idx] = now;
            else
                leave_at[idx] = now;
        end
        v.count = cnt;
        return v;
    endfunction

    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        if (!i_rst_n) begin
            threshold = '0;
            window    = '0;
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                counts[i]   = '0;
                cdowns[i]   = '0;
                join_at[i]  = '0;
                leave_at[i] = '0;
            end
            expected_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SPAM_THRESHOLD)
                    threshold = i_cfg_data[THR_W-1:0];
                else if (i_cfg_idx == CFG_REJOIN_WINDOW)
                    window = i_cfg_data[WIN_W-1:0];
            end
            if (i_res.valid && i_res.ready) begin
                got.warn          = i_res.warn;
                got.warn_for_join = i_res.warn_for_join;
                got.count         = i_res.activity_count;
                if (expected_verdicts.size() == 0) begin
                    report("result with nothing expected", 0, got.count);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.warn !== want.warn)
                        report("warn", want.warn, got.warn);
                    if (got.warn_for_join !== want.warn_for_join)
                        report("warn_for_join", want.warn_for_join, got.warn_for_join);
                    if (got.count !== want.count)
                        report("activity_count", want.count, got.count);
                end
            end
            if (i_ev.valid && i_ev.ready)
                expected_verdicts.push_back(judge_event(i_ev.client_index, i_ev.now_seconds,
                                                        i_ev.is_join));
        end
        o_pending = expected_verdicts.size();
    end

endmodule

// ===== sim/join_leave_spam_detector_tb.sv =====
// Testbench top for the join/leave spam detector: clock, reset, register writes and
// event stimulus with random stalls on both channels; verdict from jlsd_event_checker.
// Depends on jlsd_pkg, jlsd_in_if, jlsd_out_if, jlsd_event_checker and the detector RTL.
`timescale 1ns / 100ps

module join_leave_spam_detector_tb;
    import jlsd_pkg::*;

    localparam int NUM_CLIENTS    = 256;
    localparam int WARN_COUNTDOWN = 5;
    localparam int EXPIRE_SECONDS = 120;
    localparam int CYCLE_LIMIT    = 200000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                cycles  = 0;
    bit                idle_on = 1'b1;
    int                fail_count;
    int                pending;
    logic [TIME_W-1:0] clock_s;
    logic [IDX_W-1:0]  hot_ids [4];

    jlsd_in_if  ev_ch ();
    jlsd_out_if res_ch ();

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    join_leave_spam_detector #(
        .NUM_CLIENTS    (NUM_CLIENTS),
        .WARN_COUNTDOWN (WARN_COUNTDOWN),
        .EXPIRE_SECONDS (EXPIRE_SECONDS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (ev_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    jlsd_event_checker #(
        .NUM_CLIENTS    (NUM_CLIENTS),
        .WARN_COUNTDOWN (WARN_COUNTDOWN),
        .EXPIRE_SECONDS (EXPIRE_SECONDS)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev         (ev_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        res_ch.ready <= 1'b0;
        @(negedge i_clk);
        forever begin
            if (idle_on && $urandom_range(3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(15, 1)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 1)) @(negedge i_clk);
            end
        end
    end

    task automatic send_event(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] now, logic joining);
        if (idle_on && $urandom_range(5) == 0) begin
            ev_ch.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge i_clk);
        end
        ev_ch.client_index <= idx;
        ev_ch.now_seconds  <= now;
        ev_ch.is_join      <= joining;
        ev_ch.valid        <= 1'b1;
        do @(posedge i_clk); while (!ev_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        ev_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] advance_clock(bit calm);
        int unsigned pick = $urandom_range(99);
        if (calm)
            clock_s += $urandom_range(2);
        else if (pick < 80)
            clock_s += $urandom_range(3);
        else if (pick < 90)
            clock_s += $urandom_range(60);
        else if (pick < 95)
            clock_s += $urandom_range(1000, 121);
        else
            clock_s = $urandom;
        return clock_s;
    endfunction

    task automatic run_phase(logic [THR_W-1:0] thr, logic [WIN_W-1:0] win, int n, int n_hot,
                             int noise_pct, bit calm, bit keep_pool);
        logic [CFG_DATA_W-1:0] thr_word;
        settle();
        thr_word = CFG_DATA_W'($urandom);
        thr_word[THR_W-1:0] = thr;
        write_reg(CFG_SPAM_THRESHOLD, thr_word);
        write_reg(CFG_REJOIN_WINDOW, win);
        if (!keep_pool)
            foreach (hot_ids[i]) hot_ids[i] = IDX_W'($urandom);
        repeat (n) begin
            if ($urandom_range(99) < noise_pct)
                send_event(IDX_W'($urandom), $urandom, 1'($urandom));
            else
                send_event(hot_ids[$urandom_range(n_hot - 1)], advance_clock(calm),
                           1'($urandom));
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_SPAM_THRESHOLD;
        cfg_data           <= '0;
        ev_ch.valid        <= 1'b0;
        ev_ch.client_index <= '0;
        ev_ch.now_seconds  <= '0;
        ev_ch.is_join      <= 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unmapped registers must be ignored
        write_reg(CFG_SPARE_2, '1);
        write_reg(CFG_SPARE_3, '1);
        write_reg(CFG_SPAM_THRESHOLD, 16'd2);
        write_reg(CFG_REJOIN_WINDOW, 16'd10);

        // lowest client: climb to the threshold, then run the warning countdown
        send_event(8'd0, 32'd0, 1'b1);
        send_event(8'd0, 32'd5, 1'b0);
        send_event(8'd0, 32'd6, 1'b1);
        send_event(8'd0, 32'd7, 1'b0);
        send_event(8'd0, 32'd8, 1'b1);
        send_event(8'd0, 32'd9, 1'b0);
        send_event(8'd0, 32'd10, 1'b1);
        send_event(8'd0, 32'd11, 1'b0);
        send_event(8'd0, 32'd12, 1'b1);
        send_event(8'd0, 32'd13, 1'b0);
        // highest client: time wraparound, then events at the expiry boundary and far later
        send_event(8'd255, '1, 1'b1);
        send_event(8'd255, '1, 1'b0);
        send_event(8'd255, 32'd3, 1'b1);
        send_event(8'd255, 32'd3, 1'b0);
        send_event(8'd255, 32'd123, 1'b1);
        send_event(8'd255, 32'd124, 1'b0);
        send_event(8'd255, 32'h8000_0000, 1'b1);
        send_event(8'd255, 32'h8000_0001, 1'b0);

        clock_s = 32'd1000;
        run_phase(8'd0, 16'd0, 60, 4, 20, 1'b0, 1'b0);
        run_phase(8'd4, 16'd100, 150, 3, 10, 1'b0, 1'b0);
        run_phase(8'd0, 16'hFFFF, 280, 1, 0, 1'b1, 1'b0);
        run_phase(8'hFF, 16'hFFFF, 60, 1, 0, 1'b1, 1'b1);
        run_phase(8'd1, 16'd1, 80, 2, 10, 1'b1, 1'b0);
        settle();
        write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom));
        idle_on = 1'b0;
        run_phase(THR_W'($urandom_range(20, 1)), WIN_W'($urandom), 120, 4, 10, 1'b0, 1'b0);
        settle();

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
